### hw/rtl/sle_pkg.sv
// Skip-list engine package: sizes, command codes, request and result types.
// Used by skip_list_engine_unit and its checker.
package sle_pkg;
    localparam int NODES_DEF    = 1024;
    localparam int LEVELS_DEF   = 16;
    localparam int KEY_BITS_DEF = 32;

    localparam logic [1:0] CMD_SEARCH = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key;
    } t_req;

    typedef struct packed {
        logic        op_flag;
        logic [10:0] visited_count;
        logic [4:0]  found_height;
        logic        pool_full;
    } t_rsp;
endpackage

### hw/rtl/skip_list_engine_unit.sv
// Skip-list key set engine: node pool memories, free list, walk sequencer.
// Depends on sle_pkg.
//
// Channel   | Direction | Handshake            | Payload
// request   | in        | i_start & !o_busy    | i_req (t_req)
// result    | out       | o_done, one cycle    | o_rsp (t_rsp)
// seed      | in        | i_cfg_we             | i_cfg_data (32 bits)
//
// Sequence: a walk step reads a link, reads its key and compares, one step
// per list level plus one per link followed; then decide. Search reads the
// height if found; insert reads the free list and draws, with a settle and
// draw per extra level, then reads, writes and links back per level linked;
// delete reads the height, reads and writes per level unlinked and shrinks
// empty top levels. Each ends in a done state; strobe and idle coincide.
// Reset: a free-list fill sweep over all NODES entries follows; busy is high
// meanwhile. A seed write before the first draw also loads the generator.
// The receiver cannot stall; the result is shown on o_done for one cycle.
module skip_list_engine_unit
    import sle_pkg::t_req, sle_pkg::t_rsp;
#(
    parameter int NODES    = sle_pkg::NODES_DEF,
    parameter int LEVELS   = sle_pkg::LEVELS_DEF,
    parameter int KEY_BITS = sle_pkg::KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_req        i_req,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output t_rsp        o_rsp
);
    import sle_pkg::*;

    localparam int NW = $clog2(NODES);        // node index bits
    localparam int PW = NW + 1;               // pointer bits, NIL = NODES
    localparam int LW = $clog2(LEVELS);       // level index bits
    localparam int HW = $clog2(LEVELS + 1);   // height bits
    localparam int CW = $clog2(NODES + 1);    // free count bits
    localparam int AW = $clog2(NODES*LEVELS); // link memory address bits
    localparam logic [PW-1:0] NIL = PW'(NODES);

    // sequencer states
    localparam logic [3:0] S_FILL  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LINK  = 4'd2;  // read next link of cur at lvl
    localparam logic [3:0] S_KEY   = 4'd3;  // link data back, read its key
    localparam logic [3:0] S_CMP   = 4'd4;  // compare key
    localparam logic [3:0] S_DECIDE= 4'd5;  // also reads height of match
    localparam logic [3:0] S_DRAW  = 4'd6;
    localparam logic [3:0] S_RDPRE = 4'd7;  // read link of pre[i]
    localparam logic [3:0] S_WRLNK = 4'd8;  // write new node link
    localparam logic [3:0] S_DRDH  = 4'd9;  // read hit link at lvl
    localparam logic [3:0] S_DWR   = 4'd10;
    localparam logic [3:0] S_SHRINK= 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;
    localparam logic [3:0] S_HGT   = 4'd13; // height of match is back
    localparam logic [3:0] S_FREE  = 4'd14; // read free list top
    localparam logic [3:0] S_WRPRE = 4'd15; // write predecessor link

    // memories
    logic [KEY_BITS-1:0] m_key  [NODES];
    logic [HW-1:0]       m_hgt  [NODES];
    logic [PW-1:0]       m_link [NODES*LEVELS];
    logic [NW-1:0]       m_free [NODES];

    logic [PW-1:0] r_head [LEVELS];
    logic [PW-1:0] r_pre  [LEVELS];     // predecessor per level, NIL = head

    logic [3:0]          r_state;
    logic [1:0]          r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [LW-1:0]       r_lvl;
    logic [PW-1:0]       r_cur, r_nx, r_hit;
    logic [10:0]         r_vis;
    logic [HW-1:0]       r_lh, r_h, r_cap;
    logic [CW-1:0]       r_fcnt;
    logic [NW-1:0]       r_node;
    logic [31:0]         r_lcg;
    logic                r_started;
    logic [KEY_BITS-1:0] r_kdat;
    logic [HW-1:0]       r_hdat;
    logic [PW-1:0]       r_ldat;
    logic [NW-1:0]       r_fdat;
    logic                r_done;
    t_rsp                r_rsp;
    logic [NW-1:0]       r_fill;

    // link read port: address and data, head links come from flops
    logic [PW-1:0] link_rd;
    logic [PW-1:0] rd_node;
    logic [LW-1:0] rd_lvl;
    logic          r_rd_head;
    logic [LW-1:0] r_rd_lvl;

    logic [31:0] lcg_nx;
    logic [6:0]  mod100;

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    function automatic logic [AW-1:0] laddr(
        input logic [NW-1:0] n, input logic [LW-1:0] l);
        laddr = AW'(n) * AW'(LEVELS) + AW'(l);
    endfunction

    // Draw mod 100: q = (v * floor(2^36/100)) >> 36 is v/100 or one less,
    // so one compare-subtract fixes the remainder. The product is
    // registered, which is why each further draw passes through a settle state.
    logic [63:0] r_prod;
    logic [31:0] mod_rem;
    assign lcg_nx = r_lcg * LCG_MUL + LCG_ADD;
    assign mod_rem = r_lcg - 32'(r_prod[63:36]) * 32'd100;
    assign mod100 = (mod_rem >= 32'd100) ? 7'(mod_rem - 32'd100) : 7'(mod_rem);

    assign link_rd = r_rd_head ? r_head[r_rd_lvl] : r_ldat;

    always_ff @(posedge i_clk) begin
        // memory reads (registered)
        r_kdat <= m_key[rd_node[NW-1:0]];
        r_hdat <= m_hgt[rd_node[NW-1:0]];
        r_ldat <= m_link[laddr(rd_node[NW-1:0], rd_lvl)];
        r_rd_head <= (rd_node >= NIL);
        r_rd_lvl  <= rd_lvl;
        r_fdat <= m_free[r_fcnt[NW-1:0] - NW'(1)];
        r_prod <= {32'd0, r_lcg} * 64'd687194767;
    end

    always_comb begin
        rd_node = r_cur;
        rd_lvl  = r_lvl;
        case (r_state)
            S_KEY:    rd_node = link_rd;
            S_DECIDE: rd_node = r_hit;
            S_RDPRE:  rd_node = r_pre[r_lvl];
            S_DRDH:   rd_node = r_hit;
            default:  rd_node = r_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL;
            r_fill    <= '0;
            r_fcnt    <= CW'(NODES);
            r_lh      <= HW'(1);
            r_lcg     <= '0;
            r_started <= 1'b0;
            r_done    <= 1'b0;
            for (int i = 0; i < LEVELS; i++) r_head[i] <= NIL;
        end else begin
            r_done <= 1'b0;
            // seed only reaches the generator before its first draw
            if (i_cfg_we && !r_started) r_lcg <= i_cfg_data;
            case (r_state)
                S_FILL: begin
                    m_free[r_fill] <= NW'(NODES - 1) - r_fill;
                    r_fill <= r_fill + NW'(1);
                    if (r_fill == NW'(NODES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_start) begin
                    r_cmd <= i_req.cmd;
                    r_key <= KEY_BITS'(i_req.key);
                    r_cur <= NIL;
                    r_vis <= 11'd1;
                    r_lvl <= LW'(r_lh - HW'(1));
                    for (int i = 0; i < LEVELS; i++) r_pre[i] <= NIL;
                    r_rsp <= '0;
                    if (i_req.cmd == CMD_UNUSED) r_state <= S_DONE;
                    else r_state <= S_LINK;
                end
                S_LINK: r_state <= S_KEY;
                S_KEY: begin
                    r_nx <= link_rd;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_nx < NIL && r_kdat < r_key) begin
                        r_cur <= r_nx;
                        r_vis <= r_vis + 11'd1;
                        r_state <= S_LINK;
                    end else begin
                        r_pre[r_lvl] <= r_cur;
                        if (r_lvl == '0) begin
                            r_hit <= (r_nx < NIL && r_kdat == r_key) ? r_nx : NIL;
                            r_state <= S_DECIDE;
                        end else begin
                            r_lvl <= r_lvl - LW'(1);
                            r_state <= S_LINK;
                        end
                    end
                end
                S_DECIDE: begin
                    r_lvl <= '0;
                    case (r_cmd)
                        CMD_SEARCH: begin
                            r_rsp.visited_count <= r_vis;
                            r_state <= (r_hit < NIL) ? S_HGT : S_DONE;
                        end
                        CMD_INSERT: begin
                            if (r_hit < NIL) r_state <= S_DONE;
                            else if (r_fcnt == '0) begin
                                r_rsp.pool_full <= 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_fcnt <= r_fcnt - CW'(1);
                                r_h <= HW'(1);
                                r_cap <= (r_lh >= HW'(LEVELS)) ? HW'(LEVELS)
                                                              : r_lh + HW'(1);
                                if (r_started) r_lcg <= lcg_nx;
                                r_started <= 1'b1;
                                r_state <= S_FREE;
                            end
                        end
                        default: begin
                            if (r_hit < NIL) r_state <= S_HGT;
                            else r_state <= S_DONE;
                        end
                    endcase
                end
                S_HGT: begin
                    // height read was issued in the decide cycle
                    if (r_cmd == CMD_SEARCH) begin
                        r_rsp.found_height <= 5'(r_hdat);
                        r_state <= S_DONE;
                    end else begin
                        r_h <= (r_hdat > HW'(LEVELS)) ? HW'(LEVELS) : r_hdat;
                        r_state <= S_DRDH;
                    end
                end
                S_FREE: begin
                    r_node <= r_fdat;
                    r_state <= S_DRAW;
                end
                S_DRAW: begin
                    // r_lcg holds current draw, r_prod its product
                    if (mod100 < 7'd50 && r_h < r_cap) begin
                        r_h <= r_h + HW'(1);
                        r_lcg <= lcg_nx;
                        r_state <= S_SHRINK;
                    end else begin
                        m_key[r_node] <= r_key;
                        m_hgt[r_node] <= r_h;
                        if (r_h > r_lh) r_lh <= r_h;
                        r_state <= S_RDPRE;
                    end
                end
                S_SHRINK: begin
                    if (r_cmd == CMD_INSERT) r_state <= S_DRAW; // product settle
                    else if (r_lh > HW'(1) && r_head[LW'(r_lh - HW'(1))] == NIL)
                        r_lh <= r_lh - HW'(1);
                    else begin
                        r_rsp.op_flag <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_RDPRE: r_state <= S_WRLNK;
                S_WRLNK: begin
                    m_link[laddr(r_node, r_lvl)] <=
                        (r_pre[r_lvl] >= NIL && HW'(r_lvl) >= r_lh) ? NIL : link_rd;
                    r_state <= S_WRPRE;
                end
                S_WRPRE: begin
                    if (r_pre[r_lvl] >= NIL) r_head[r_lvl] <= PW'(r_node);
                    else m_link[laddr(r_pre[r_lvl][NW-1:0], r_lvl)] <= PW'(r_node);
                    if (HW'(r_lvl) + HW'(1) >= r_h) begin
                        r_rsp.op_flag <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_lvl <= r_lvl + LW'(1);
                        r_state <= S_RDPRE;
                    end
                end
                S_DRDH: r_state <= S_DWR;
                S_DWR: begin
                    if (r_pre[r_lvl] >= NIL) r_head[r_lvl] <= link_rd;
                    else m_link[laddr(r_pre[r_lvl][NW-1:0], r_lvl)] <= link_rd;
                    if (HW'(r_lvl) + HW'(1) >= r_h) begin
                        if (r_fcnt < CW'(NODES)) begin
                            m_free[r_fcnt[NW-1:0]] <= r_hit[NW-1:0];
                            r_fcnt <= r_fcnt + CW'(1);
                        end
                        r_state <= S_SHRINK;
                    end else begin
                        r_lvl <= r_lvl + LW'(1);
                        r_state <= S_DRDH;
                    end
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/sle_checker.sv
// Port-level checker for skip_list_engine_unit, attached by bind.
// Depends on sle_pkg.
module sle_checker
    import sle_pkg::t_req, sle_pkg::t_rsp;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done,
    input t_rsp o_rsp
);
    import sle_pkg::*;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("no busy after accept");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("done while busy");
    a_flag_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_rsp.op_flag && o_rsp.pool_full)) else $error("flag and full");
endmodule

bind skip_list_engine_unit sle_checker u_sle_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
    .o_busy(o_busy), .o_done(o_done), .o_rsp(o_rsp));
